// ----- hw/rtl/grr_pkg.sv -----
// ============================================================================
// Gamma ramp resampler package
// Shared constants, types and the command and status structs that join the
// controller and the datapath.
// ============================================================================
`default_nettype none

package grr_pkg;

  localparam int TableEntries = 256;
  localparam int MaxRamp      = 4096;
  localparam int AddrW        = $clog2(TableEntries);
  localparam int RampW        = 13;
  localparam int IdxW         = 12;
  localparam int ColorW       = 16;
  localparam int NumColors    = 3;
  localparam int ColorSelW    = $clog2(NumColors);
  localparam int EntryW       = NumColors * ColorW;
  localparam int ProdAW       = IdxW + AddrW;
  localparam int NumW         = ColorW + IdxW;
  localparam int DvdBW        = NumW + 1;
  localparam int RemBW        = IdxW + 1;
  localparam int DivASteps    = AddrW;
  localparam int DivBSteps    = ColorW;
  localparam int MulSteps     = 2 * NumColors;
  localparam int MulIdxW      = $clog2(MulSteps);
  localparam int CntW         = $clog2(DivBSteps);

  typedef enum logic {
    ModeLoad  = 1'b0,
    ModeQuery = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    RdDirect = 2'd0,
    RdLo     = 2'd1,
    RdHi     = 2'd2
  } rd_sel_e;

  typedef logic [NumColors-1:0][ColorW-1:0] rgb_t;

  typedef struct packed {
    logic                take;
    logic                query_start;
    logic                div_a_init;
    logic                div_a_step;
    logic                rd_en;
    rd_sel_e             rd_sel;
    logic                cap_lo;
    logic                mul_step;
    logic [MulIdxW-1:0]  mul_idx;
    logic                div_b_init;
    logic                div_b_step;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic direct;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/grr_ctrl.sv -----
// ============================================================================
// Gamma ramp resampler controller
// One-hot state machine that sequences loads, table reads, the index
// divider, the shared multiplier and the blend dividers.
// ============================================================================
`default_nettype none

module grr_ctrl
  import grr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire mode_e in_mode_i,
  output logic       in_ready_o,
  input  wire sts_t  sts_i,
  input  wire logic  out_busy_i,
  output cmd_t       cmd_o
);

  typedef enum logic [8:0] {
    StIdle     = 9'b000000001,
    StClassify = 9'b000000010,
    StDivA     = 9'b000000100,
    StRdLo     = 9'b000001000,
    StRdHi     = 9'b000010000,
    StMul      = 9'b000100000,
    StDivBInit = 9'b001000000,
    StDivB     = 9'b010000000,
    StFinish   = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_mode_i == ModeQuery) begin
            cmd_o.query_start = 1'b1;
            state_d           = StClassify;
          end
        end
      end
      StClassify: begin
        cnt_d = '0;
        if (sts_i.oor) begin
          state_d = StFinish;
        end else if (sts_i.direct) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RdDirect;
          state_d      = StFinish;
        end else begin
          cmd_o.div_a_init = 1'b1;
          state_d          = StDivA;
        end
      end
      StDivA: begin
        cmd_o.div_a_step = 1'b1;
        if (cnt_q == CntW'(DivASteps - 1)) begin
          cnt_d   = '0;
          state_d = StRdLo;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StRdLo: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RdLo;
        state_d      = StRdHi;
      end
      StRdHi: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RdHi;
        cmd_o.cap_lo = 1'b1;
        cnt_d        = '0;
        state_d      = StMul;
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_idx  = cnt_q[MulIdxW-1:0];
        if (cnt_q == CntW'(MulSteps - 1)) begin
          cnt_d   = '0;
          state_d = StDivBInit;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDivBInit: begin
        cmd_o.div_b_init = 1'b1;
        cnt_d            = '0;
        state_d          = StDivB;
      end
      StDivB: begin
        cmd_o.div_b_step = 1'b1;
        if (cnt_q == CntW'(DivBSteps - 1)) begin
          cnt_d   = '0;
          state_d = StFinish;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StFinish: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_query_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.query_start |=> !in_ready_o)
    else $error("input accepted while a query is in progress");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !out_busy_i)
    else $error("result loaded into a full output register");

  a_div_a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivA) |-> (cnt_q < CntW'(DivASteps)))
    else $error("index divider ran past its step count");

endmodule

`default_nettype wire

// ----- hw/rtl/grr_datapath.sv -----
// ============================================================================
// Gamma ramp resampler datapath
// Gamma table memory, ramp size register, restoring index divider, shared
// multiplier and three blend dividers with half-up rounding.
// ============================================================================
`default_nettype none

module grr_datapath
  import grr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output sts_t                  sts_o,
  input  wire mode_e            in_mode_i,
  input  wire logic [IdxW-1:0]  in_index_i,
  input  wire rgb_t             in_rgb_i,
  input  wire logic             cfg_we_i,
  input  wire logic [RampW-1:0] cfg_wdata_i,
  output rgb_t                  res_rgb_o,
  output logic                  res_oor_o
);

  logic [EntryW-1:0] mem [TableEntries];
  rgb_t              rd_data_q;
  logic              mem_we;
  logic [AddrW-1:0]  rd_addr;

  logic [RampW-1:0]  ramp_size_q;
  logic [IdxW-1:0]   idx_q;
  logic [IdxW-1:0]   d_q;
  logic [AddrW-1:0]  dir_addr_q;
  logic              oor_q;
  logic              direct_q;

  logic [IdxW-1:0]   rem_a_q;
  logic [AddrW-1:0]  quo_a_q;
  logic [ProdAW-1:0] prod_a;
  logic [IdxW:0]     shift_a;
  logic              bit_a;

  rgb_t                        lo_q;
  logic [NumColors-1:0][NumW-1:0]  num_q;
  logic [ColorSelW-1:0]        mul_col;
  logic                        mul_odd;
  logic [ColorW-1:0]           mul_a;
  logic [IdxW-1:0]             mul_b;
  logic [NumW-1:0]             mul_p;

  logic [NumColors-1:0][RemBW-1:0]  rem_b_q;
  rgb_t                             quo_b_q;
  logic [RemBW-1:0]                 d2;

  logic              small_ramp;
  logic [RampW-1:0]  last_idx;

  assign small_ramp = ramp_size_q <= RampW'(TableEntries);
  assign last_idx   = ramp_size_q - 1'b1;
  assign mem_we     = cmd_i.take && (in_mode_i == ModeLoad) &&
                      (in_index_i < IdxW'(TableEntries));

  always_comb begin
    case (cmd_i.rd_sel)
      RdDirect: rd_addr = dir_addr_q;
      RdLo:     rd_addr = quo_a_q;
      RdHi:     rd_addr = quo_a_q + 1'b1;
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_index_i[AddrW-1:0]] <= in_rgb_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_size_q <= RampW'(TableEntries);
      oor_q       <= 1'b0;
      direct_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ramp_size_q <= (cfg_wdata_i > RampW'(MaxRamp)) ? RampW'(MaxRamp) : cfg_wdata_i;
      end
      if (cmd_i.query_start) begin
        oor_q    <= {1'b0, in_index_i} >= ramp_size_q;
        direct_q <= small_ramp || ({1'b0, in_index_i} == last_idx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      idx_q      <= in_index_i;
      d_q        <= last_idx[IdxW-1:0];
      dir_addr_q <= small_ramp ? in_index_i[AddrW-1:0] : AddrW'(TableEntries - 1);
    end
  end

  assign prod_a  = {idx_q, {AddrW{1'b0}}} - ProdAW'(idx_q);
  assign shift_a = {rem_a_q, quo_a_q[AddrW-1]};
  assign bit_a   = shift_a >= {1'b0, d_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_a_init) begin
      rem_a_q <= prod_a[ProdAW-1:AddrW];
      quo_a_q <= prod_a[AddrW-1:0];
    end else if (cmd_i.div_a_step) begin
      rem_a_q <= bit_a ? IdxW'(shift_a - {1'b0, d_q}) : shift_a[IdxW-1:0];
      quo_a_q <= {quo_a_q[AddrW-2:0], bit_a};
    end
  end

  assign mul_col = cmd_i.mul_idx[MulIdxW-1:1];
  assign mul_odd = cmd_i.mul_idx[0];
  assign mul_a   = mul_odd ? rd_data_q[mul_col] : lo_q[mul_col];
  assign mul_b   = mul_odd ? rem_a_q : (d_q - rem_a_q);
  assign mul_p   = NumW'(mul_a) * NumW'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_lo) begin
      lo_q <= rd_data_q;
    end
    if (cmd_i.mul_step) begin
      num_q[mul_col] <= mul_odd ? (num_q[mul_col] + mul_p) : mul_p;
    end
  end

  assign d2 = {d_q, 1'b0};

  for (genvar c = 0; c < NumColors; c++) begin : g_blend
    logic [DvdBW-1:0] dvd_b;
    logic [RemBW:0]   shift_b;
    logic             bit_b;

    assign dvd_b   = {num_q[c], 1'b0} + DvdBW'(d_q);
    assign shift_b = {rem_b_q[c], quo_b_q[c][ColorW-1]};
    assign bit_b   = shift_b >= {1'b0, d2};

    always_ff @(posedge clk_i) begin
      if (cmd_i.div_b_init) begin
        rem_b_q[c] <= dvd_b[DvdBW-1:ColorW];
        quo_b_q[c] <= dvd_b[ColorW-1:0];
      end else if (cmd_i.div_b_step) begin
        rem_b_q[c] <= bit_b ? RemBW'(shift_b - {1'b0, d2}) : shift_b[RemBW-1:0];
        quo_b_q[c] <= {quo_b_q[c][ColorW-2:0], bit_b};
      end
    end
  end

  assign sts_o.oor    = oor_q;
  assign sts_o.direct = direct_q;

  always_comb begin
    if (oor_q) begin
      res_rgb_o = '0;
    end else if (direct_q) begin
      res_rgb_o = rd_data_q;
    end else begin
      res_rgb_o = quo_b_q;
    end
  end
  assign res_oor_o = oor_q;

  a_rem_a_below_d: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_a_step |-> (rem_a_q < d_q))
    else $error("index divider remainder not below the divisor");

  a_lower_entry_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_en && (cmd_i.rd_sel == RdHi)) |-> (quo_a_q <= AddrW'(TableEntries - 2)))
    else $error("interpolation position beyond the second-to-last entry");

endmodule

`default_nettype wire

// ----- hw/rtl/gamma_ramp_resampler.sv -----
// ============================================================================
// Gamma ramp resampler
// Holds a 256-entry RGB gamma table and answers queries for entries of a
// display ramp of configurable size, interpolating for large ramps.
// ============================================================================
// A load transaction (tuser 0) writes one table entry and gives no result;
// load indices above 255 are dropped. A query transaction (tuser 1) gives one
// result. Out-of-range queries pass from the classify step to the output
// load; queries of ramps of at most 256 entries and the last index of a
// larger ramp also read one table entry on the way. Interpolated queries run
// the classify step, the bit-per-cycle index divider, the two table reads,
// the shared 16x12 multiplier, the bit-per-cycle blend dividers and the
// output load in that order. The output load waits while the output register
// is full. The next transaction is accepted at the earliest in the cycle
// after the output register is loaded. The input accepts no new transaction
// while a query is being worked on, but does take one while a finished result
// waits in the output register. The user must write the ramp size only while
// the block is idle; the block itself does not enforce this. Values above
// 4096 saturate.
`default_nettype none

module gamma_ramp_resampler
  import grr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [RampW-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // index[11:0], red_in[27:12], green_in[43:28], blue_in[59:44], zero[63:60]
  input  wire logic [63:0]      s_axis_tdata_i,
  // mode[0]
  input  wire logic             s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // red_out[15:0], green_out[31:16], blue_out[47:32]
  output logic [47:0]           m_axis_tdata_o,
  // out_of_range[0]
  output logic                  m_axis_tuser_o
);

  cmd_t  cmd;
  sts_t  sts;
  rgb_t  in_rgb;
  rgb_t  res_rgb;
  logic  res_oor;
  logic  out_busy;
  mode_e in_mode;

  logic  m_valid_q, m_valid_d;
  rgb_t  m_rgb_q;
  logic  m_oor_q;

  assign in_mode   = mode_e'(s_axis_tuser_i);
  assign in_rgb[0] = s_axis_tdata_i[27:12];
  assign in_rgb[1] = s_axis_tdata_i[43:28];
  assign in_rgb[2] = s_axis_tdata_i[59:44];

  assign out_busy  = m_valid_q && !m_axis_tready_i;

  grr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_mode_i  (in_mode),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .out_busy_i (out_busy),
    .cmd_o      (cmd)
  );

  grr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_mode_i   (in_mode),
    .in_index_i  (s_axis_tdata_i[IdxW-1:0]),
    .in_rgb_i    (in_rgb),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_rgb_o   (res_rgb),
    .res_oor_o   (res_oor)
  );

  always_comb begin
    if (cmd.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      m_rgb_q <= res_rgb;
      m_oor_q <= res_oor;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_rgb_q[2], m_rgb_q[1], m_rgb_q[0]};
  assign m_axis_tuser_o  = m_oor_q;

endmodule

`default_nettype wire

// ----- dv/gamma_ramp_resampler_chk.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Gamma ramp resampler result checker
// Watches the configuration port and both stream channels. It keeps its own
// copy of the gamma table and of the ramp size, works out the ramp entry for
// every accepted query, and compares each result field by field in order.
// ============================================================================

module gamma_ramp_resampler_chk
  import grr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RampW-1:0] cfg_wdata_i,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [63:0]      s_tdata_i,
  input  logic             s_tuser_i,
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [47:0]      m_tdata_i,
  input  logic             m_tuser_i,
  output int               errors_o,
  output int               pending_o
);

  typedef struct packed {
    logic              oor;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
  } ramp_entry_t;

  logic [ColorW-1:0] red_tab   [TableEntries];
  logic [ColorW-1:0] green_tab [TableEntries];
  logic [ColorW-1:0] blue_tab  [TableEntries];
  int unsigned       ramp_size;
  ramp_entry_t       ramp_entries_q [$];
  int                mismatches = 0;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  function automatic logic [ColorW-1:0] blend_color(logic [ColorW-1:0] lo,
                                                    logic [ColorW-1:0] hi,
                                                    longint unsigned frac,
                                                    longint unsigned span);
    longint unsigned num;
    num = longint'(lo) * (span - frac) + longint'(hi) * frac;
    return ColorW'((num * 2 + span) / (span * 2));
  endfunction

  function automatic ramp_entry_t predict_ramp_entry(logic [IdxW-1:0] idx);
    ramp_entry_t     res;
    longint unsigned span;
    longint unsigned prod;
    longint unsigned seg;
    longint unsigned frac;
    int unsigned     lo;
    res = '0;
    if (idx >= ramp_size) begin
      res.oor = 1'b1;
    end else if (ramp_size <= TableEntries) begin
      res.red   = red_tab[idx[AddrW-1:0]];
      res.green = green_tab[idx[AddrW-1:0]];
      res.blue  = blue_tab[idx[AddrW-1:0]];
    end else if (idx == ramp_size - 1) begin
      res.red   = red_tab[TableEntries-1];
      res.green = green_tab[TableEntries-1];
      res.blue  = blue_tab[TableEntries-1];
    end else begin
      span = ramp_size - 1;
      prod = longint'(idx) * (TableEntries - 1);
      seg  = prod / span;
      frac = prod % span;
      if (seg > TableEntries - 2) begin
        seg = TableEntries - 2;
      end
      lo        = int'(seg);
      res.red   = blend_color(red_tab[lo], red_tab[lo+1], frac, span);
      res.green = blend_color(green_tab[lo], green_tab[lo+1], frac, span);
      res.blue  = blend_color(blue_tab[lo], blue_tab[lo+1], frac, span);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    ramp_entry_t      got;
    ramp_entry_t      want;
    logic [IdxW-1:0]  idx;
    if (!rst_ni) begin
      ramp_size = TableEntries;
      ramp_entries_q.delete();
      for (int i = 0; i < TableEntries; i++) begin
        red_tab[i]   = '0;
        green_tab[i] = '0;
        blue_tab[i]  = '0;
      end
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tuser_i, m_tdata_i};
        if (ramp_entries_q.size() == 0) begin
          report_mismatch("result with no query pending", got, 0);
        end else begin
          want = ramp_entries_q.pop_front();
          if (got.red != want.red) report_mismatch("red_out", got.red, want.red);
          if (got.green != want.green) report_mismatch("green_out", got.green, want.green);
          if (got.blue != want.blue) report_mismatch("blue_out", got.blue, want.blue);
          if (got.oor != want.oor) report_mismatch("out_of_range", got.oor, want.oor);
        end
      end
      if (cfg_we_i) begin
        ramp_size = (cfg_wdata_i > MaxRamp) ? MaxRamp : cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        idx = s_tdata_i[IdxW-1:0];
        if (mode_e'(s_tuser_i) == ModeLoad) begin
          if (idx < TableEntries) begin
            red_tab[idx[AddrW-1:0]]   = s_tdata_i[27:12];
            green_tab[idx[AddrW-1:0]] = s_tdata_i[43:28];
            blue_tab[idx[AddrW-1:0]]  = s_tdata_i[59:44];
          end
        end else begin
          ramp_entries_q.push_back(predict_ramp_entry(idx));
        end
      end
    end
    errors_o  <= mismatches;
    pending_o <= ramp_entries_q.size();
  end

endmodule

// ----- dv/gamma_ramp_resampler_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Gamma ramp resampler testbench
// Fills the gamma table, runs directed loads and queries at the ramp size
// extremes, then random phases of loads and queries under several ramp sizes
// with random idle bursts on both stream channels, and reports the verdict.
// ============================================================================

module gamma_ramp_resampler_tb;
  import grr_pkg::*;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [RampW-1:0] cfg_wdata = '0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [63:0]      s_tdata   = '0;
  logic             s_tuser   = 1'b0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [47:0]      m_tdata;
  logic             m_tuser;
  int               errors;
  int               pending;

  bit               calm       = 1'b0;
  int               stall_left = 0;
  int               loads_sent   = 0;
  int               queries_sent = 0;
  int               settings_used = 0;
  int unsigned      ramp_plan [12] = '{256, 4096, 1000, 257, 2, 255, 3000, 4097, 8191, 1,
                                       0, 4096};

  always #5 clk_i = ~clk_i;

  gamma_ramp_resampler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  gamma_ramp_resampler_chk u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_item(mode_e mode, logic [IdxW-1:0] idx, logic [ColorW-1:0] red,
                           logic [ColorW-1:0] green, logic [ColorW-1:0] blue);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0, blue, green, red, idx};
    do @(posedge clk_i); while (!s_tready);
    if (mode == ModeLoad) loads_sent++;
    else queries_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_ramp(int unsigned size);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= RampW'(size);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [IdxW-1:0] pick_ramp_index(int unsigned size);
    int unsigned n;
    n = (size > MaxRamp) ? MaxRamp : size;
    case ($urandom_range(0, 9))
      0: return (n == 0) ? '0 : IdxW'(n - 1);
      1: return IdxW'($urandom_range(0, 4095));
      2: return (n >= 4096) ? IdxW'(4095) : IdxW'(n);
      default: return (n == 0) ? '0 : IdxW'($urandom_range(0, n - 1));
    endcase
  endfunction

  initial begin
    logic [IdxW-1:0] idx;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < TableEntries; i++) begin
      send_item(ModeLoad, IdxW'(i), ColorW'($urandom), ColorW'($urandom), ColorW'($urandom));
    end

    send_item(ModeLoad, 0, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_item(ModeLoad, 255, 16'h0000, 16'hFFFF, 16'h0000);
    send_item(ModeLoad, 256, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(ModeLoad, 4095, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 0, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(ModeQuery, 256, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 4095, 16'h0000, 16'h0000, 16'h0000);
    set_ramp(4096);
    send_item(ModeQuery, 0, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 4095, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 1, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 2048, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 4094, 16'h0000, 16'h0000, 16'h0000);
    set_ramp(8191);
    send_item(ModeQuery, 4095, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 17, 16'h0000, 16'h0000, 16'h0000);
    set_ramp(1);
    send_item(ModeQuery, 0, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 1, 16'h0000, 16'h0000, 16'h0000);
    set_ramp(0);
    send_item(ModeQuery, 0, 16'h0000, 16'h0000, 16'h0000);
    set_ramp(257);
    send_item(ModeQuery, 256, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 255, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 128, 16'h0000, 16'h0000, 16'h0000);
    send_item(ModeQuery, 257, 16'h0000, 16'h0000, 16'h0000);

    ramp_plan[2] = $urandom_range(258, 4095);
    for (int p = 0; p < 12; p++) begin
      set_ramp(ramp_plan[p]);
      if (p >= 10) calm = 1'b1;
      for (int k = 0; k < 128; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          idx = ($urandom_range(0, 6) == 0) ? IdxW'($urandom_range(256, 4095))
                                             : IdxW'($urandom_range(0, 255));
          send_item(ModeLoad, idx, ColorW'($urandom), ColorW'($urandom), ColorW'($urandom));
        end else begin
          send_item(ModeQuery, pick_ramp_index(ramp_plan[p]), ColorW'($urandom),
                    ColorW'($urandom), ColorW'($urandom));
        end
      end
    end

    drain();
    $display("Covered %0d loads and %0d queries over %0d ramp size writes, %s", loads_sent,
             queries_sent, settings_used, "from sizes 0 and 1 up to 4096 and saturating 8191.");
    if (errors == 0 && pending == 0) begin
      $display("gamma_ramp_resampler_tb OK");
    end else begin
      $display("gamma_ramp_resampler_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still pending.", pending);
    $display("gamma_ramp_resampler_tb NOT OK");
    $finish;
  end

endmodule
